[rtl/owb_pkg.sv]
package owb_pkg;

    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 3;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_RST_LOW  = 3'd1;
    localparam logic [2:0] PH_RST_WAIT = 3'd2;
    localparam logic [2:0] PH_RST_TAIL = 3'd3;
    localparam logic [2:0] PH_SLOT     = 3'd4;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_RESET = 3'd1;
    localparam logic [2:0] OP_WBYTE = 3'd2;
    localparam logic [2:0] OP_RBYTE = 3'd3;
    localparam logic [2:0] OP_WBIT  = 3'd4;
    localparam logic [2:0] OP_RBIT  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] IDX_RESET_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_PRES_SAMPLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_RESET_TAIL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_SLOT        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_ZERO_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] IDX_SHORT_LOW   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] IDX_READ_SAMPLE = 3'd6;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_ticks;
        logic [CFG_W-1:0] presence_sample_ticks;
        logic [CFG_W-1:0] reset_tail_ticks;
        logic [CFG_W-1:0] slot_ticks;
        logic [CFG_W-1:0] zero_low_ticks;
        logic [CFG_W-1:0] short_low_ticks;
        logic [CFG_W-1:0] read_sample_ticks;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        reset_low_ticks:       10'd480,
        presence_sample_ticks: 10'd70,
        reset_tail_ticks:      10'd410,
        slot_ticks:            10'd70,
        zero_low_ticks:        10'd60,
        short_low_ticks:       10'd6,
        read_sample_ticks:     10'd9
    };

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] write_data;
        logic       bus_sense;
    } item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       presence;
        logic       rejected;
    } result_t;

endpackage

[rtl/one_wire_bus_master.sv]
// 1-Wire bus master, one tick request per clock while m_tready does not stall the output.
// Each accepted request passes the input register, then the result register to m_tvalid.
// Throughput: one request per cycle unless m_tready stalls; the input register and
// the result register each hold one entry, and the core state advances once per request.
// Reset: synchronous active-low aresetn idles the bus, clears the state and
// loads the default timing registers.
module one_wire_bus_master import owb_pkg::*; #(
    parameter int COUNT_WIDTH = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,  // write_data[7:0], bus_sense[8]
    input  logic [7:0]           s_tuser,  // cmd[2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // drive_low[0], busy_res[1], done_res[2], read_data[10:3], presence[11], rejected[12]
    output logic [15:0]          m_tdata
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t res;
    result_t res_reg;
    logic    m_valid_reg;
    logic    advance;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    owb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    owb_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.cmd        <= s_tuser[2:0];
            item_reg.write_data <= s_tdata[7:0];
            item_reg.bus_sense  <= s_tdata[8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, res_reg.rejected, res_reg.presence, res_reg.read_data,
                       res_reg.done_res, res_reg.busy_res, res_reg.drive_low};

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.done_res |-> !res_reg.busy_res)
        else $error("done with busy still set");

    a_read_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !res_reg.done_res |-> res_reg.read_data == 8'h00)
        else $error("read data outside a done result");

    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("processed request lost its result");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg && !in_valid_reg)
        else $error("pipeline not empty after reset");
`endif

endmodule

[rtl/owb_cfg.sv]
module owb_cfg import owb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                IDX_RESET_LOW:   cfg_reg.reset_low_ticks       <= cfg_wdata;
                IDX_PRES_SAMPLE: cfg_reg.presence_sample_ticks <= cfg_wdata;
                IDX_RESET_TAIL:  cfg_reg.reset_tail_ticks      <= cfg_wdata;
                IDX_SLOT:        cfg_reg.slot_ticks            <= cfg_wdata;
                IDX_ZERO_LOW:    cfg_reg.zero_low_ticks        <= cfg_wdata;
                IDX_SHORT_LOW:   cfg_reg.short_low_ticks       <= cfg_wdata;
                IDX_READ_SAMPLE: cfg_reg.read_sample_ticks     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/owb_core.sv]
module owb_core import owb_pkg::*; #(
    parameter int COUNT_WIDTH = 10
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    localparam int CMP_W = ((COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W) + 1;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [CMP_W-1:0] CNT_MAX_W =
        {{(CMP_W-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};

    logic [2:0]             phase_reg,    phase_next;
    logic [2:0]             op_reg,       op_next;
    logic [COUNT_WIDTH-1:0] tick_reg,     tick_next;
    logic [3:0]             bits_reg,     bits_next;
    logic [7:0]             shift_reg,    shift_next;
    logic                   presence_reg, presence_next;

    logic [CMP_W-1:0] tick_w;
    logic             is_write;
    logic [CFG_W-1:0] low_ticks;
    logic [CFG_W-1:0] last_raw;
    logic [CMP_W-1:0] last_w;
    logic [CFG_W:0]   samp_sum;
    logic [CMP_W-1:0] samp_w;
    logic             drive;
    logic             done;
    logic             rej;
    logic [7:0]       rd;

    function automatic logic phase_over(input logic [COUNT_WIDTH-1:0] tc,
                                        input logic [CFG_W-1:0] len);
        logic [CMP_W-1:0] tc_plus;
        begin
            tc_plus = CMP_W'(tc) + CMP_W'(1);
            phase_over = (tc_plus >= CMP_W'(len)) || (tc == CNT_MAX);
        end
    endfunction

    always_comb begin
        phase_next    = phase_reg;
        op_next       = op_reg;
        tick_next     = tick_reg;
        bits_next     = bits_reg;
        shift_next    = shift_reg;
        presence_next = presence_reg;
        drive         = 1'b0;
        done          = 1'b0;
        rej           = 1'b0;
        rd            = 8'h00;
        is_write      = 1'b0;
        low_ticks     = '0;
        last_raw      = '0;
        last_w        = '0;
        samp_sum      = '0;
        samp_w        = '0;
        tick_w        = '0;

        if (item.cmd inside {[OP_RESET:OP_RBIT]}) begin
            if (phase_reg != PH_IDLE) begin
                rej = 1'b1;
            end else begin
                op_next   = item.cmd;
                tick_next = '0;
                if (item.cmd == OP_RESET) begin
                    phase_next = PH_RST_LOW;
                end else begin
                    phase_next = PH_SLOT;
                    bits_next  = (item.cmd == OP_WBYTE || item.cmd == OP_RBYTE) ? 4'd8 : 4'd1;
                    if (item.cmd == OP_WBYTE) begin
                        shift_next = item.write_data;
                    end else if (item.cmd == OP_WBIT) begin
                        shift_next = {7'b0, item.write_data[0]};
                    end else begin
                        shift_next = 8'h00;
                    end
                end
            end
        end

        tick_w = CMP_W'(tick_next);

        case (phase_next)
            PH_RST_LOW: begin
                drive = 1'b1;
                if (phase_over(tick_next, cfg.reset_low_ticks)) begin
                    phase_next = PH_RST_WAIT;
                    tick_next  = '0;
                end else begin
                    tick_next = tick_next + 1'b1;
                end
            end
            PH_RST_WAIT: begin
                if (phase_over(tick_next, cfg.presence_sample_ticks)) begin
                    presence_next = ~item.bus_sense;
                    phase_next    = PH_RST_TAIL;
                    tick_next     = '0;
                end else begin
                    tick_next = tick_next + 1'b1;
                end
            end
            PH_RST_TAIL: begin
                if (phase_over(tick_next, cfg.reset_tail_ticks)) begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                end else begin
                    tick_next = tick_next + 1'b1;
                end
            end
            PH_SLOT: begin
                is_write  = (op_next == OP_WBYTE) || (op_next == OP_WBIT);
                low_ticks = (is_write && !shift_next[0]) ? cfg.zero_low_ticks
                                                         : cfg.short_low_ticks;
                last_raw  = (cfg.slot_ticks != '0) ? cfg.slot_ticks - 1'b1 : '0;
                last_w    = (CMP_W'(last_raw) > CNT_MAX_W) ? CNT_MAX_W : CMP_W'(last_raw);
                drive     = tick_w < CMP_W'(low_ticks);
                samp_sum  = {1'b0, low_ticks} + {1'b0, cfg.read_sample_ticks};
                if (samp_sum != '0) begin
                    samp_sum = samp_sum - 1'b1;
                end
                samp_w = (CMP_W'(samp_sum) > last_w) ? last_w : CMP_W'(samp_sum);
                if (!is_write && (tick_w == samp_w)) begin
                    shift_next = {item.bus_sense, shift_next[7:1]};
                end
                if (phase_over(tick_next, cfg.slot_ticks)) begin
                    tick_next = '0;
                    if (is_write) begin
                        shift_next = {1'b0, shift_next[7:1]};
                    end
                    bits_next = bits_next - 1'b1;
                    if (bits_next == 4'd0) begin
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                        if (op_next == OP_RBYTE) begin
                            rd = shift_next;
                        end else if (op_next == OP_RBIT) begin
                            rd = {7'b0, shift_next[7]};
                        end
                    end
                end else begin
                    tick_next = tick_next + 1'b1;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            op_reg       <= OP_NONE;
            tick_reg     <= '0;
            bits_reg     <= '0;
            shift_reg    <= '0;
            presence_reg <= 1'b0;
        end else if (step_en) begin
            phase_reg    <= phase_next;
            op_reg       <= op_next;
            tick_reg     <= tick_next;
            bits_reg     <= bits_next;
            shift_reg    <= shift_next;
            presence_reg <= presence_next;
        end
    end

    always_comb begin
        res.drive_low = drive;
        res.busy_res  = phase_next != PH_IDLE;
        res.done_res  = done;
        res.read_data = rd;
        res.presence  = presence_next;
        res.rejected  = rej;
    end

endmodule
